[src/gbba_pkg.sv]
// Shared types and constants for the group bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none

package gbba_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NOSPACE = 2'd1,
        STATUS_INVALID = 2'd2,
        STATUS_ALREADY = 2'd3
    } status_t;

    // Request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_DATA_BLOCK = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GROUP_COUNT      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_BLOCKS     = 2'd2;
    localparam int CFG_DATA_W = 17;

    // Field widths
    localparam int BLK_W      = 17;
    localparam int GC_W       = 4;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;
    localparam int STATUS_W   = 2;

    // Reset values of the configuration registers
    localparam logic             FDB_RESET = 1'b1;
    localparam logic [GC_W-1:0]  GC_RESET  = 4'd8;
    localparam logic [BLK_W-1:0] TB_RESET  = 17'd65537;

endpackage

`default_nettype wire

[src/gbba_word_ram.sv]
// Simple dual-port bitmap word memory, registered read, one write port.
`timescale 1ns / 1ps
`default_nettype none

module gbba_word_ram #(
    parameter int DEPTH  = 1024,
    parameter int WORD_W = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WORD_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/group_bitmap_block_allocator.sv]
// Top level: group bitmap block allocator with word-wide bitmap memory.
`timescale 1ns / 1ps
`default_nettype none

// Block allocator over MAX_GROUPS groups of BLOCKS_PER_GROUP blocks each.
// Input channel s_*: s_tuser is the request kind (allocate / free),
// s_tdata carries the block number to free. One result per request on m_*:
// m_tuser is the status, m_tdata the allocated block and the total free count.
// Configuration goes through cfg_wr_en / cfg_index / cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// The bitmap sits in a 64-bit-word memory with a registered read; each group
// keeps a free count and a hint to its lowest word that may hold a clear
// bit, so a scan normally starts right where the last one stopped.
// Allocate: S_AGRP passes over full groups, then S_AEVAL reads words from
// the hint on until one has a clear bit; no space is answered once the groups
// run out. Free: S_FDIV finds the group index by repeated subtraction, then
// S_FEVAL clears the bit; an invalid block number goes straight to S_DONE.
// One request is in flight at a time; s_tready is high only when idle.
// The result sits in an output register; a stalled receiver holds it and the
// block still takes and works the next request, waiting only to deliver it.
// After reset the bitmap memory is cleared, one word per cycle, over all
// MAX_GROUPS * ceil(BLOCKS_PER_GROUP / 64) words (1024 by default); no
// request is taken meanwhile, configuration writes are.
module group_bitmap_block_allocator #(
    parameter int MAX_GROUPS       = 8,
    parameter int BLOCKS_PER_GROUP = 8192
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [gbba_pkg::S_TDATA_W-1:0]    s_tdata,  // [16:0] block_number
    input  wire logic                              s_tuser,  // [0] op
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [gbba_pkg::M_TDATA_W-1:0]         m_tdata,  // [16:0] allocated_block,
                                                             // [33:17] free_total
    output logic [gbba_pkg::STATUS_W-1:0]          m_tuser,  // [1:0] status
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [gbba_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  wire logic [gbba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int BLK_W     = gbba_pkg::BLK_W;
    localparam int W         = 64;
    localparam int LW        = 6;
    localparam int WPG       = (BLOCKS_PER_GROUP + W - 1) / W;
    localparam int DEPTH     = MAX_GROUPS * WPG;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AXW       = $clog2(DEPTH + 1);
    localparam int WIW       = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int HW        = $clog2(WPG + 1);
    localparam int GIW       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GW        = $clog2(MAX_GROUPS + 1);
    localparam int NBITS     = MAX_GROUPS * BLOCKS_PER_GROUP;
    localparam int BW        = $clog2(NBITS + 1);
    localparam int GCW       = (BLOCKS_PER_GROUP > 16383) ? 16 : 14;
    localparam int TW        = (NBITS > 131071) ? $clog2(NBITS + 1) : 17;
    localparam int TFREE_MAX = (NBITS > 131071) ? NBITS : 131071;
    localparam int TAIL      = BLOCKS_PER_GROUP % W;
    // bits past the end of a group in its last word read as used
    localparam logic [W-1:0] TAIL_MASK =
        (TAIL == 0) ? '0 : ~((W'(1) << TAIL) - W'(1));

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_AGRP, S_AEVAL, S_FDIV, S_FEVAL, S_DONE
    } state_t;

    state_t                    state_reg;
    logic [AW-1:0]             clr_cnt_reg;

    logic                      fdb_reg;
    logic [gbba_pkg::GC_W-1:0] gc_reg;
    logic [BLK_W-1:0]          tb_reg;

    logic [GCW-1:0]            gcount_reg [MAX_GROUPS];
    logic [HW-1:0]             hint_reg   [MAX_GROUPS];
    logic [TW-1:0]             total_reg;

    logic [GW-1:0]             g_reg;
    logic [AXW-1:0]            gaddr_reg;
    logic [BW-1:0]             gbase_reg;
    logic [WIW-1:0]            w_reg;
    logic [AW-1:0]             rd_addr_reg;
    logic [BLK_W-1:0]          rem_reg;
    gbba_pkg::status_t         status_reg;
    logic [BLK_W-1:0]          alloc_reg;

    logic                      m_tvalid_reg;
    logic [gbba_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [gbba_pkg::STATUS_W-1:0]  m_tuser_reg;

    // memory ports
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [W-1:0]              ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [W-1:0]              ram_rdata;

    gbba_word_ram #(
        .DEPTH  (DEPTH),
        .WORD_W (W),
        .ADDR_W (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- request decode ----------------
    logic [BLK_W-1:0] in_blk;
    logic             in_op;
    logic [BLK_W-1:0] in_rel;
    logic             in_invalid;

    assign in_blk     = s_tdata[BLK_W-1:0];
    assign in_op      = s_tuser;
    assign in_rel     = in_blk - BLK_W'(fdb_reg);
    assign in_invalid = (in_blk == '0) || (in_blk > tb_reg) ||
                        (32'(in_rel) >= 32'(NBITS));

    // ---------------- current group ----------------
    logic [GIW-1:0] g_idx;
    logic           grp_end;
    logic [GCW-1:0] cur_gcount;
    logic [HW-1:0]  cur_hint;
    logic           grp_skip;

    assign g_idx      = g_reg[GIW-1:0];
    assign grp_end    = (32'(g_reg) >= 32'(MAX_GROUPS)) || (32'(g_reg) >= 32'(gc_reg));
    assign cur_gcount = gcount_reg[g_idx];
    assign cur_hint   = hint_reg[g_idx];
    assign grp_skip   = (cur_gcount == '0) || (cur_hint == HW'(WPG));

    // ---------------- word evaluation (allocate) ----------------
    logic [W-1:0]    word_inv;
    logic [W-1:0]    word_low;
    logic            word_full;
    logic [LW-1:0]   word_bit;
    logic [HW-1:0]   w_next;
    logic [31:0]     alloc_sum;

    assign word_inv  = ~(ram_rdata | ((w_reg == WIW'(WPG - 1)) ? TAIL_MASK : '0));
    assign word_low  = word_inv & (~word_inv + W'(1));
    assign word_full = (word_inv == '0);
    assign w_next    = HW'(w_reg) + HW'(1);

    always_comb begin
        word_bit = '0;
        for (int i = 0; i < W; i++) begin
            if (word_low[i]) begin
                word_bit = word_bit | LW'(i);
            end
        end
    end

    assign alloc_sum = 32'(gbase_reg) + 32'({w_reg, word_bit}) + 32'(fdb_reg);

    // ---------------- free path ----------------
    logic            rem_ge;
    logic [WIW-1:0]  rem_word;
    logic [W-1:0]    rem_mask;
    logic            rem_used;

    assign rem_ge   = (rem_reg >= BLK_W'(BLOCKS_PER_GROUP));
    assign rem_word = rem_reg[LW +: WIW];
    assign rem_mask = W'(1) << rem_reg[LW-1:0];
    assign rem_used = ram_rdata[rem_reg[LW-1:0]];

    // ---------------- memory access ----------------
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = rd_addr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = rd_addr_reg;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            S_AGRP: begin
                if (!grp_end && !grp_skip) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(gaddr_reg + AXW'(cur_hint));
                end
            end
            S_AEVAL: begin
                if (word_full) begin
                    ram_re    = (w_next != HW'(WPG));
                    ram_raddr = rd_addr_reg + AW'(1);
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | word_low;
                end
            end
            S_FDIV: begin
                if (!rem_ge) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(gaddr_reg + AXW'(rem_word));
                end
            end
            S_FEVAL: begin
                ram_we    = rem_used;
                ram_wdata = ram_rdata & ~rem_mask;
            end
            default: begin
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            fdb_reg      <= gbba_pkg::FDB_RESET;
            gc_reg       <= gbba_pkg::GC_RESET;
            tb_reg       <= gbba_pkg::TB_RESET;
            total_reg    <= TW'(NBITS);
            for (int i = 0; i < MAX_GROUPS; i++) begin
                gcount_reg[i] <= GCW'(BLOCKS_PER_GROUP);
                hint_reg[i]   <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    gbba_pkg::CFG_FIRST_DATA_BLOCK: fdb_reg <= cfg_wdata[0];
                    gbba_pkg::CFG_GROUP_COUNT:      gc_reg  <= cfg_wdata[gbba_pkg::GC_W-1:0];
                    gbba_pkg::CFG_TOTAL_BLOCKS:     tb_reg  <= cfg_wdata[BLK_W-1:0];
                    default: begin
                    end
                endcase
            end

            // output register: load a finished result, or drop one taken downstream
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        g_reg     <= '0;
                        gaddr_reg <= '0;
                        gbase_reg <= '0;
                        rem_reg   <= in_rel;
                        if (in_op == gbba_pkg::OP_ALLOC) begin
                            state_reg <= S_AGRP;
                        end else if (in_invalid) begin
                            status_reg <= gbba_pkg::STATUS_INVALID;
                            alloc_reg  <= '0;
                            state_reg  <= S_DONE;
                        end else begin
                            state_reg <= S_FDIV;
                        end
                    end
                end
                S_AGRP: begin
                    if (grp_end) begin
                        status_reg <= gbba_pkg::STATUS_NOSPACE;
                        alloc_reg  <= '0;
                        state_reg  <= S_DONE;
                    end else if (grp_skip) begin
                        g_reg     <= g_reg + GW'(1);
                        gaddr_reg <= gaddr_reg + AXW'(WPG);
                        gbase_reg <= gbase_reg + BW'(BLOCKS_PER_GROUP);
                    end else begin
                        w_reg       <= WIW'(cur_hint);
                        rd_addr_reg <= ram_raddr;
                        state_reg   <= S_AEVAL;
                    end
                end
                S_AEVAL: begin
                    if (word_full) begin
                        // every word below the hint is known full
                        hint_reg[g_idx] <= w_next;
                        if (w_next == HW'(WPG)) begin
                            g_reg     <= g_reg + GW'(1);
                            gaddr_reg <= gaddr_reg + AXW'(WPG);
                            gbase_reg <= gbase_reg + BW'(BLOCKS_PER_GROUP);
                            state_reg <= S_AGRP;
                        end else begin
                            w_reg       <= WIW'(w_next);
                            rd_addr_reg <= rd_addr_reg + AW'(1);
                        end
                    end else begin
                        gcount_reg[g_idx] <= cur_gcount - GCW'(1);
                        if (total_reg != '0) begin
                            total_reg <= total_reg - TW'(1);
                        end
                        status_reg <= gbba_pkg::STATUS_OK;
                        alloc_reg  <= alloc_sum[BLK_W-1:0];
                        state_reg  <= S_DONE;
                    end
                end
                S_FDIV: begin
                    if (rem_ge) begin
                        rem_reg   <= rem_reg - BLK_W'(BLOCKS_PER_GROUP);
                        g_reg     <= g_reg + GW'(1);
                        gaddr_reg <= gaddr_reg + AXW'(WPG);
                    end else begin
                        // word address kept for the write-back
                        rd_addr_reg <= ram_raddr;
                        state_reg   <= S_FEVAL;
                    end
                end
                S_FEVAL: begin
                    status_reg <= rem_used ? gbba_pkg::STATUS_OK : gbba_pkg::STATUS_ALREADY;
                    alloc_reg  <= '0;
                    // counts go up even when the bit was already clear
                    if (cur_gcount != '1) begin
                        gcount_reg[g_idx] <= cur_gcount + GCW'(1);
                    end
                    if (32'(total_reg) < 32'(TFREE_MAX)) begin
                        total_reg <= total_reg + TW'(1);
                    end
                    if (HW'(rem_word) < cur_hint) begin
                        hint_reg[g_idx] <= HW'(rem_word);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {6'b0, total_reg[BLK_W-1:0], alloc_reg};
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[src/gbba_checker.sv]
// Port-level checker for the group bitmap block allocator, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module gbba_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [gbba_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [gbba_pkg::STATUS_W-1:0]     m_tuser
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one request at a time: not ready in the cycle after a transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    // only a successful request may carry an allocated block number
    a_alloc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != gbba_pkg::STATUS_OK) |-> (m_tdata[16:0] == 17'd0))
        else $error("allocated block set on a failed request");

endmodule

bind group_bitmap_block_allocator gbba_checker u_gbba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
